@@ design/lc2k_pkg.sv @@
// shared constants, codes and beat types for the lc2k instruction executor
`timescale 1ns / 1ps
package lc2k_pkg;

  localparam int MEM_WORDS = 65536;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int NUM_REGS  = 8;
  localparam int REG_AW    = $clog2(NUM_REGS);
  localparam int WORD_W    = 32;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HOSTRD,
    S_FETCH,
    S_REGA,
    S_REGB,
    S_EXEC,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        address;
    logic signed [31:0] write_data;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic [15:0]        program_counter;
    logic               halted;
    logic               fault;
    logic               reg_written;
    logic [2:0]         reg_index;
    logic signed [31:0] reg_value;
    logic               mem_written;
    logic [15:0]        mem_address;
    logic [31:0]        instr_count;
  } out_t;

endpackage

@@ design/lc2k_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps
module lc2k_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ design/lc2k_instruction_executor.sv @@
// lc2k instruction executor: multicycle sequencer around word memory and register file
// result strobe: registered, in the cycle after a write or status beat; after an in-range
//   host read it follows the host-read state, after a step beat it follows fetch, two
//   register reads, execute and (lw only) load; steps do not overlap on the single ports
// busy drops as the strobe goes out, so the next beat may start in the strobe cycle
// reset clears pc, registers (valid bits), halt flag and count; word memory is undefined
// results go out on done for one cycle and cannot be stalled
`timescale 1ns / 1ps
module lc2k_instruction_executor (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lc2k_pkg::in_t     request,
  output logic              done,
  output lc2k_pkg::out_t    result
);

  lc2k_pkg::state_t state, state_next;

  logic [31:0]                   instr, instr_next;
  logic [31:0]                   va, va_next;
  logic [31:0]                   vb, vb_next;
  logic [15:0]                   pc_reg, pc_next;
  logic                          halt_flag, halt_next;
  logic [31:0]                   count, count_next;
  logic [lc2k_pkg::NUM_REGS-1:0] rf_valid;
  lc2k_pkg::out_t                result_next;
  logic                          done_next;

  logic                          mem_en, mem_we;
  logic [lc2k_pkg::MEM_AW-1:0]   mem_addr;
  logic [31:0]                   mem_wdata, mem_rdata;
  logic                          rf_en, rf_we;
  logic [lc2k_pkg::REG_AW-1:0]   rf_addr;
  logic [31:0]                   rf_wdata, rf_rdata;

  logic                          accept;
  logic                          host_ok;
  logic                          ea_ok;
  lc2k_pkg::opcode_t             op;
  logic [2:0]                    ra, rb, rd;
  logic signed [33:0]            off_x, pc_inc, alu_a, alu_b, alu_sum;
  lc2k_pkg::out_t                status;

  function automatic logic mem_ok(input logic signed [33:0] x);
    return !x[33] && (x[32:0] < 33'(lc2k_pkg::MEM_WORDS));
  endfunction

  lc2k_ram #(.WIDTH(lc2k_pkg::WORD_W), .DEPTH(lc2k_pkg::MEM_WORDS)) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  lc2k_ram #(.WIDTH(lc2k_pkg::WORD_W), .DEPTH(lc2k_pkg::NUM_REGS)) u_rf (
    .clk   (clk),
    .en    (rf_en),
    .we    (rf_we),
    .addr  (rf_addr),
    .wdata (rf_wdata),
    .rdata (rf_rdata)
  );

  assign busy    = (state != lc2k_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign host_ok = {1'b0, request.address} < 17'(lc2k_pkg::MEM_WORDS);

  assign op    = lc2k_pkg::opcode_t'(instr[24:22]);
  assign ra    = instr[21:19];
  assign rb    = instr[18:16];
  assign rd    = instr[2:0];
  assign off_x = {{18{instr[15]}}, instr[15:0]};
  assign pc_inc = $signed({18'b0, pc_reg}) + 34'sd1;

  // shared adder: data add, effective address or branch target
  always_comb begin
    unique case (op)
      lc2k_pkg::OP_ADD: begin
        alu_a = {{2{va[31]}}, va};
        alu_b = {{2{vb[31]}}, vb};
      end
      lc2k_pkg::OP_LW, lc2k_pkg::OP_SW: begin
        alu_a = {{2{va[31]}}, va};
        alu_b = off_x;
      end
      default: begin
        alu_a = pc_inc;
        alu_b = off_x;
      end
    endcase
  end

  assign alu_sum = alu_a + alu_b;
  assign ea_ok   = mem_ok(alu_sum);

  always_comb begin
    status                 = '0;
    status.program_counter = pc_reg;
    status.halted          = halt_flag;
    status.instr_count     = count;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lc2k_pkg::S_IDLE: begin
        if (accept) begin
          if (request.action == lc2k_pkg::ACT_READ && host_ok) begin
            state_next = lc2k_pkg::S_HOSTRD;
          end else if (request.action == lc2k_pkg::ACT_STEP && !halt_flag) begin
            state_next = lc2k_pkg::S_FETCH;
          end
        end
      end
      lc2k_pkg::S_HOSTRD: state_next = lc2k_pkg::S_IDLE;
      lc2k_pkg::S_FETCH:  state_next = lc2k_pkg::S_REGA;
      lc2k_pkg::S_REGA:   state_next = lc2k_pkg::S_REGB;
      lc2k_pkg::S_REGB:   state_next = lc2k_pkg::S_EXEC;
      lc2k_pkg::S_EXEC: begin
        if (op == lc2k_pkg::OP_LW && ea_ok) begin
          state_next = lc2k_pkg::S_LOAD;
        end else begin
          state_next = lc2k_pkg::S_IDLE;
        end
      end
      lc2k_pkg::S_LOAD:   state_next = lc2k_pkg::S_IDLE;
      default:            state_next = lc2k_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    lc2k_pkg::out_t     res;
    logic signed [33:0] npc;
    logic [31:0]        rval;
    logic               stay;
    logic               flt;
    logic               halt_n;

    res    = status;
    npc    = pc_inc;
    rval   = '0;
    stay   = 1'b0;
    flt    = 1'b0;
    halt_n = halt_flag;

    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = pc_reg[lc2k_pkg::MEM_AW-1:0];
    mem_wdata   = request.write_data;
    rf_en       = 1'b0;
    rf_we       = 1'b0;
    rf_addr     = ra;
    rf_wdata    = '0;
    instr_next  = instr;
    va_next     = va;
    vb_next     = vb;
    pc_next     = pc_reg;
    halt_next   = halt_flag;
    count_next  = count;
    result_next = result;
    done_next   = 1'b0;

    unique case (state)
      lc2k_pkg::S_IDLE: begin
        if (accept) begin
          priority if (request.action == lc2k_pkg::ACT_WRITE) begin
            mem_en      = host_ok;
            mem_we      = 1'b1;
            mem_addr    = request.address[lc2k_pkg::MEM_AW-1:0];
            result_next = status;
            done_next   = 1'b1;
          end else if (request.action == lc2k_pkg::ACT_READ) begin
            mem_en   = host_ok;
            mem_addr = request.address[lc2k_pkg::MEM_AW-1:0];
            if (!host_ok) begin
              result_next = status;
              done_next   = 1'b1;
            end
          end else if (request.action == lc2k_pkg::ACT_STEP && !halt_flag) begin
            mem_en = 1'b1;
          end else begin
            result_next = status;
            done_next   = 1'b1;
          end
        end
      end
      lc2k_pkg::S_HOSTRD: begin
        res.read_data = mem_rdata;
        result_next   = res;
        done_next     = 1'b1;
      end
      lc2k_pkg::S_FETCH: begin
        instr_next = mem_rdata;
        rf_en      = 1'b1;
        rf_addr    = mem_rdata[21:19];
      end
      lc2k_pkg::S_REGA: begin
        va_next = rf_valid[ra] ? rf_rdata : '0;
        rf_en   = 1'b1;
        rf_addr = rb;
      end
      lc2k_pkg::S_REGB: begin
        vb_next = rf_valid[rb] ? rf_rdata : '0;
      end
      lc2k_pkg::S_EXEC: begin
        count_next      = (count == '1) ? count : count + 32'd1;
        res.instr_count = count_next;
        unique case (op)
          lc2k_pkg::OP_ADD, lc2k_pkg::OP_NOR: begin
            rval            = (op == lc2k_pkg::OP_ADD) ? alu_sum[31:0] : ~(va | vb);
            rf_en           = 1'b1;
            rf_we           = 1'b1;
            rf_addr         = rd;
            rf_wdata        = rval;
            res.reg_written = 1'b1;
            res.reg_index   = rd;
            res.reg_value   = rval;
          end
          lc2k_pkg::OP_LW, lc2k_pkg::OP_SW: begin
            mem_addr = alu_sum[lc2k_pkg::MEM_AW-1:0];
            if (!ea_ok) begin
              stay = 1'b1;
              flt  = 1'b1;
            end else if (op == lc2k_pkg::OP_LW) begin
              mem_en = 1'b1;
            end else begin
              mem_en          = 1'b1;
              mem_we          = 1'b1;
              mem_wdata       = vb;
              res.mem_written = 1'b1;
              res.mem_address = alu_sum[15:0];
            end
          end
          lc2k_pkg::OP_BEQ: begin
            if (va == vb) begin
              npc = alu_sum;
            end
          end
          lc2k_pkg::OP_JALR: begin
            rval            = pc_inc[31:0];
            rf_en           = 1'b1;
            rf_we           = 1'b1;
            rf_addr         = rb;
            rf_wdata        = rval;
            res.reg_written = 1'b1;
            res.reg_index   = rb;
            res.reg_value   = rval;
            npc             = (ra == rb) ? pc_inc : {{2{va[31]}}, va};
          end
          lc2k_pkg::OP_HALT: begin
            halt_n = 1'b1;
          end
          lc2k_pkg::OP_NOOP: begin
          end
        endcase
        if (stay) begin
          halt_n = 1'b1;
        end else if (!mem_ok(npc)) begin
          flt    = 1'b1;
          halt_n = 1'b1;
        end else begin
          pc_next = npc[15:0];
        end
        halt_next           = halt_n;
        res.halted          = halt_n;
        res.fault           = flt;
        res.program_counter = pc_next;
        if (!(op == lc2k_pkg::OP_LW && ea_ok)) begin
          result_next = res;
          done_next   = 1'b1;
        end
      end
      lc2k_pkg::S_LOAD: begin
        rf_en           = 1'b1;
        rf_we           = 1'b1;
        rf_addr         = rb;
        rf_wdata        = mem_rdata;
        res.reg_written = 1'b1;
        res.reg_index   = rb;
        res.reg_value   = mem_rdata;
        // a halt here can only come from the next pc running off the end
        res.fault       = halt_flag;
        result_next     = res;
        done_next       = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lc2k_pkg::S_IDLE;
      pc_reg    <= '0;
      halt_flag <= 1'b0;
      count     <= '0;
      rf_valid  <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      pc_reg    <= pc_next;
      halt_flag <= halt_next;
      count     <= count_next;
      done      <= done_next;
      if (rf_we) begin
        rf_valid[rf_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    instr  <= instr_next;
    va     <= va_next;
    vb     <= vb_next;
    result <= result_next;
  end

  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    done && result.fault |-> result.halted)
    else $error("fault reported without halt");

  a_one_write_kind: assert property (@(posedge clk) disable iff (rst)
    done && result.mem_written |-> !result.reg_written)
    else $error("store beat also reports a register write");

  a_load_after_exec: assert property (@(posedge clk) disable iff (rst)
    state == lc2k_pkg::S_LOAD |-> $past(state) == lc2k_pkg::S_EXEC)
    else $error("load state not entered from execute");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_flag |=> halt_flag)
    else $error("halt flag cleared without reset");

endmodule
